// File: hdl/sdpi_pkg.sv
// Package with the widths, constants and stage numbers of the soft-disk pair interaction core.
`timescale 1ns / 1ps
`default_nettype none
package sdpi_pkg;

    localparam int POS_FRAC_BITS = 16;
    localparam int ANGLE_BITS    = 16;
    localparam int QUARTER_BITS  = ANGLE_BITS - 2;
    localparam int POS_W         = 24;
    localparam int DIFF_W        = 26;
    localparam int UNIT_BITS     = 22;
    localparam int ROOT_W        = 24;
    localparam int REM_W         = 2 * ROOT_W;
    localparam int MAG_W         = 32 + ROOT_W - POS_FRAC_BITS;
    localparam int MAG_LO_W      = 24;
    localparam int MAG_HI_W      = MAG_W - MAG_LO_W;
    localparam int QUOT_W        = UNIT_BITS + 1;

    localparam int NSTAGE   = 55;
    localparam int ST_SQ0   = 6;
    localparam int ST_ROOT  = 29;
    localparam int ST_MAG   = 30;
    localparam int ST_DIV0  = 31;
    localparam int ST_DIVL  = ST_DIV0 + QUOT_W - 1;
    localparam int ST_MUL   = ST_DIVL + 1;
    localparam int ST_SINE  = 10;

    localparam logic [1:0] REG_HALF_BOX       = 2'd0;
    localparam logic [1:0] REG_CONTACT_RADIUS = 2'd1;
    localparam logic [1:0] REG_STIFFNESS      = 2'd2;
    localparam logic [1:0] REG_ALIGN_ORDER    = 2'd3;

    localparam logic [22:0] HALF_BOX_RESET       = 23'd655360;
    localparam logic [22:0] CONTACT_RADIUS_RESET = 23'd6554;
    localparam logic [31:0] STIFFNESS_RESET      = 32'd0;
    localparam logic [3:0]  ALIGN_ORDER_RESET    = 4'd1;
    localparam logic [REM_W-1:0] TSQ_RESET       = 48'd171819664;

    localparam logic signed [33:0] SIN_C1 = 34'sd1686629713;
    localparam logic signed [33:0] SIN_C3 = 34'sd693598669;
    localparam logic signed [33:0] SIN_C5 = 34'sd85569306;
    localparam logic signed [33:0] SIN_C7 = 34'sd5026995;
    localparam logic signed [33:0] SIN_C9 = 34'sd172272;

endpackage
`default_nettype wire

// File: hdl/soft_disk_pair_interaction_core.sv
// Throughput: one pair per cycle while the output is not stalled; the square root takes 24 stages and the unit
// vector divider 23 stages, one result bit per stage.
// A stalled output freezes the whole pipeline and holds s_tready low.
// Reset empties the pipeline and loads the registers with their reset values.
`timescale 1ns / 1ps
`default_nettype none
module soft_disk_pair_interaction_core
    import sdpi_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_x, a_y, b_x, b_y, a_angle, b_angle
    input  wire logic [127:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // force_x, force_y, align_term
    output logic [79:0]       m_tdata,
    // in_contact, coincident
    output logic [1:0]        m_tuser
);

    logic [22:0]       half_box_reg;
    logic [22:0]       contact_radius_reg;
    logic [31:0]       stiffness_reg;
    logic [3:0]        align_order_reg;
    logic [REM_W-1:0]  tsq_reg;
    logic [ROOT_W-1:0] twor;
    logic              adv;
    logic [NSTAGE:1]   v_reg;

    logic signed [DIFF_W-1:0] hb_s, two_hb;
    logic signed [DIFF_W-1:0] dx_reg [1:ST_ROOT];
    logic signed [DIFF_W-1:0] dy_reg [1:ST_ROOT];
    logic [ANGLE_BITS-1:0]    ph1_reg, ph2_reg;

    logic [30:0]       sx_reg   [3:8];
    logic [30:0]       sx2_reg  [4:8];
    logic [1:0]        quad_reg [3:9];
    logic signed [33:0] p_reg   [5:9];
    logic [15:0]       al_reg   [ST_SINE:NSTAGE];

    logic [REM_W:0]    sqx_reg, sqy_reg;
    logic              cont_reg [5:NSTAGE];
    logic              coin_reg [5:NSTAGE];
    logic [REM_W-1:0]  rem_reg  [5:ST_ROOT];
    logic [ROOT_W-1:0] root_reg [5:ST_ROOT];

    logic [MAG_W-1:0]  mag_reg  [ST_MAG:ST_MUL];
    logic              sgx_reg  [ST_MAG:ST_MUL];
    logic              sgy_reg  [ST_MAG:ST_MUL];
    logic [ROOT_W-1:0] dist_reg [ST_MAG:ST_DIVL];
    logic [ROOT_W-1:0] dvx_reg  [ST_MAG:ST_DIVL];
    logic [ROOT_W-1:0] dvy_reg  [ST_MAG:ST_DIVL];
    logic [QUOT_W-1:0] dqx_reg  [ST_MAG:ST_DIVL];
    logic [QUOT_W-1:0] dqy_reg  [ST_MAG:ST_DIVL];
    logic              lsbx_reg, lsby_reg;

    logic [MAG_LO_W+QUOT_W-1:0] plx_reg, ply_reg;
    logic [MAG_HI_W+QUOT_W-1:0] phx_reg, phy_reg;
    logic [31:0]                fx_reg, fy_reg;

    function automatic logic signed [33:0] horner_step(input logic signed [33:0] p,
                                                       input logic [30:0] x,
                                                       input logic signed [33:0] c);
        logic signed [65:0] prod;
        logic signed [65:0] adj;
        prod = p * $signed({1'b0, x});
        adj = prod[65] ? prod + 66'sd1073741823 : prod;
        adj = adj >>> 30;
        return c + $signed(adj[33:0]);
    endfunction

    function automatic logic [31:0] sat_force(input logic [63:0] prod, input logic neg,
                                              input logic act);
        logic [41:0] q;
        logic [31:0] res;
        q = prod[63:UNIT_BITS];
        if (!act)
        begin
            res = 32'd0;
        end
        else if (neg)
        begin
            res = (q > 42'h0_8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
        end
        else
        begin
            res = (q > 42'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
        return res;
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_box_reg       <= HALF_BOX_RESET;
            contact_radius_reg <= CONTACT_RADIUS_RESET;
            stiffness_reg      <= STIFFNESS_RESET;
            align_order_reg    <= ALIGN_ORDER_RESET;
            tsq_reg            <= TSQ_RESET;
        end
        else
        begin
            tsq_reg <= twor * twor;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HALF_BOX:       half_box_reg       <= cfg_data[22:0];
                    REG_CONTACT_RADIUS: contact_radius_reg <= cfg_data[22:0];
                    REG_STIFFNESS:      stiffness_reg      <= cfg_data;
                    REG_ALIGN_ORDER:    align_order_reg    <= cfg_data[3:0];
                    default:            ;
                endcase
            end
        end
    end

    assign twor   = {contact_radius_reg, 1'b0};
    assign hb_s   = $signed({3'b000, half_box_reg});
    assign two_hb = $signed({2'b00, half_box_reg, 1'b0});

    assign adv      = m_tready | ~v_reg[NSTAGE];
    assign s_tready = adv;
    assign m_tvalid = v_reg[NSTAGE];
    assign m_tdata  = {al_reg[NSTAGE], fy_reg, fx_reg};
    assign m_tuser  = {coin_reg[NSTAGE], cont_reg[NSTAGE]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NSTAGE-1:1], s_tvalid};
        end
    end

    // Front end: separation, minimum image, alignment phase, squares and contact test.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg[1] <= $signed({{2{s_tdata[71]}}, s_tdata[71:48]})
                       - $signed({{2{s_tdata[23]}}, s_tdata[23:0]});
            dy_reg[1] <= $signed({{2{s_tdata[95]}}, s_tdata[95:72]})
                       - $signed({{2{s_tdata[47]}}, s_tdata[47:24]});
            ph1_reg   <= s_tdata[96 +: ANGLE_BITS] - s_tdata[112 +: ANGLE_BITS];

            dx_reg[2] <= (dx_reg[1] > hb_s) ? dx_reg[1] - two_hb : dx_reg[1];
            dy_reg[2] <= (dy_reg[1] > hb_s) ? dy_reg[1] - two_hb : dy_reg[1];
            ph2_reg   <= ph1_reg * {{(ANGLE_BITS-4){1'b0}}, align_order_reg};

            dx_reg[3] <= (dx_reg[2] < -hb_s) ? dx_reg[2] + two_hb : dx_reg[2];
            dy_reg[3] <= (dy_reg[2] < -hb_s) ? dy_reg[2] + two_hb : dy_reg[2];
        end
    end

    logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
    logic [REM_W+1:0]           d2;
    logic                       contact5, coinc5;

    assign sqx_full = dx_reg[3] * dx_reg[3];
    assign sqy_full = dy_reg[3] * dy_reg[3];
    assign d2       = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign contact5 = d2 < {2'b00, tsq_reg};
    assign coinc5   = d2 == '0;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg     <= sqx_full[REM_W:0];
            sqy_reg     <= sqy_full[REM_W:0];
            cont_reg[5] <= contact5;
            coin_reg[5] <= coinc5;
            rem_reg[5]  <= (contact5 && !coinc5) ? d2[REM_W-1:0] : '0;
            root_reg[5] <= '0;
        end
    end

    for (genvar g = 4; g <= ST_ROOT; g++)
    begin : g_dcarry
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dx_reg[g] <= dx_reg[g-1];
                dy_reg[g] <= dy_reg[g-1];
            end
        end
    end

    for (genvar g = 6; g <= NSTAGE; g++)
    begin : g_flags
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cont_reg[g] <= cont_reg[g-1];
                coin_reg[g] <= coin_reg[g-1];
            end
        end
    end

    // Alignment sine: quarter-turn fold and Horner evaluation.
    logic [QUARTER_BITS:0] xr;
    logic [61:0]           xx;
    logic [33:0]           sine_rnd;
    logic [14:0]           sine_mag;

    assign xr = ph2_reg[QUARTER_BITS] ?
                ({1'b1, {QUARTER_BITS{1'b0}}} - {1'b0, ph2_reg[QUARTER_BITS-1:0]}) :
                {1'b0, ph2_reg[QUARTER_BITS-1:0]};
    assign xx = sx_reg[3] * sx_reg[3];
    assign sine_rnd = (p_reg[9][33] ? 34'd0 : p_reg[9]) + 34'd16384;
    assign sine_mag = (sine_rnd[33:15] > 19'd32767) ? 15'h7FFF : sine_rnd[29:15];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg[3]    <= {xr, {(30-QUARTER_BITS){1'b0}}};
            quad_reg[3]  <= ph2_reg[ANGLE_BITS-1:ANGLE_BITS-2];
            sx2_reg[4]   <= xx[60:30];
            p_reg[5]     <= horner_step(SIN_C9, sx2_reg[4], -SIN_C7);
            p_reg[6]     <= horner_step(p_reg[5], sx2_reg[5], SIN_C5);
            p_reg[7]     <= horner_step(p_reg[6], sx2_reg[6], -SIN_C3);
            p_reg[8]     <= horner_step(p_reg[7], sx2_reg[7], SIN_C1);
            p_reg[9]     <= horner_step(p_reg[8], sx_reg[8], 34'sd0);
            al_reg[ST_SINE] <= quad_reg[9][1] ? (16'd0 - {1'b0, sine_mag}) : {1'b0, sine_mag};
        end
    end

    for (genvar g = 4; g <= 8; g++)
    begin : g_scarry
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sx_reg[g] <= sx_reg[g-1];
            end
        end
    end

    for (genvar g = 5; g <= 8; g++)
    begin : g_s2carry
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sx2_reg[g] <= sx2_reg[g-1];
            end
        end
    end

    for (genvar g = 4; g <= 9; g++)
    begin : g_qcarry
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                quad_reg[g] <= quad_reg[g-1];
            end
        end
    end

    for (genvar g = ST_SINE + 1; g <= NSTAGE; g++)
    begin : g_acarry
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                al_reg[g] <= al_reg[g-1];
            end
        end
    end

    // Square root, one result bit per stage.
    for (genvar g = ST_SQ0; g <= ST_ROOT; g++)
    begin : g_sqrt
        localparam int I = ST_ROOT - g;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] diff;
        logic             ge;

        assign trial = ({{(REM_W+2-ROOT_W){1'b0}}, root_reg[g-1]} << (I + 1))
                     + ({{(REM_W+1){1'b0}}, 1'b1} << (2 * I));
        assign diff  = {2'b00, rem_reg[g-1]} - trial;
        assign ge    = {2'b00, rem_reg[g-1]} >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[g]  <= ge ? diff[REM_W-1:0] : rem_reg[g-1];
                root_reg[g] <= root_reg[g-1] | (ge ? (ROOT_W'(1) << I) : '0);
            end
        end
    end

    // Magnitude of the repulsion and set-up of the unit vector division.
    logic [ROOT_W-1:0]        overlap;
    logic [31+ROOT_W:0]       mprod;
    logic signed [DIFF_W-1:0] ndx, ndy;
    logic [ROOT_W:0]          adx, ady;

    assign overlap = twor - root_reg[ST_ROOT];
    assign mprod   = stiffness_reg * overlap;
    assign ndx     = -dx_reg[ST_ROOT];
    assign ndy     = -dy_reg[ST_ROOT];
    assign adx     = dx_reg[ST_ROOT][DIFF_W-1] ? ndx[ROOT_W:0] : dx_reg[ST_ROOT][ROOT_W:0];
    assign ady     = dy_reg[ST_ROOT][DIFF_W-1] ? ndy[ROOT_W:0] : dy_reg[ST_ROOT][ROOT_W:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg[ST_MAG]  <= mprod[31+ROOT_W:POS_FRAC_BITS];
            sgx_reg[ST_MAG]  <= dx_reg[ST_ROOT][DIFF_W-1];
            sgy_reg[ST_MAG]  <= dy_reg[ST_ROOT][DIFF_W-1];
            dist_reg[ST_MAG] <= root_reg[ST_ROOT];
            dvx_reg[ST_MAG]  <= adx[ROOT_W:1];
            dvy_reg[ST_MAG]  <= ady[ROOT_W:1];
            lsbx_reg         <= adx[0];
            lsby_reg         <= ady[0];
            dqx_reg[ST_MAG]  <= '0;
            dqy_reg[ST_MAG]  <= '0;
        end
    end

    for (genvar g = ST_MAG + 1; g <= ST_MUL; g++)
    begin : g_mcarry
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                mag_reg[g] <= mag_reg[g-1];
                sgx_reg[g] <= sgx_reg[g-1];
                sgy_reg[g] <= sgy_reg[g-1];
            end
        end
    end

    // Restoring division of the scaled separation by the distance.
    for (genvar g = ST_DIV0; g <= ST_DIVL; g++)
    begin : g_div
        localparam int K = ST_DIVL - g;
        logic [ROOT_W:0] shx, shy, subx, suby;
        logic            gex, gey;

        assign shx  = {dvx_reg[g-1], (g == ST_DIV0) ? lsbx_reg : 1'b0};
        assign shy  = {dvy_reg[g-1], (g == ST_DIV0) ? lsby_reg : 1'b0};
        assign subx = shx - {1'b0, dist_reg[g-1]};
        assign suby = shy - {1'b0, dist_reg[g-1]};
        assign gex  = shx >= {1'b0, dist_reg[g-1]};
        assign gey  = shy >= {1'b0, dist_reg[g-1]};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dist_reg[g] <= dist_reg[g-1];
                dvx_reg[g]  <= gex ? subx[ROOT_W-1:0] : shx[ROOT_W-1:0];
                dvy_reg[g]  <= gey ? suby[ROOT_W-1:0] : shy[ROOT_W-1:0];
                dqx_reg[g]  <= dqx_reg[g-1] | (gex ? (QUOT_W'(1) << K) : '0);
                dqy_reg[g]  <= dqy_reg[g-1] | (gey ? (QUOT_W'(1) << K) : '0);
            end
        end
    end

    // Force components: split product, then truncation, sign and saturation.
    logic [63:0] prod_x, prod_y;
    logic        act;

    assign prod_x = {{(64-MAG_LO_W-QUOT_W){1'b0}}, plx_reg}
                  + {{(64-MAG_HI_W-QUOT_W-MAG_LO_W){1'b0}}, phx_reg, {MAG_LO_W{1'b0}}};
    assign prod_y = {{(64-MAG_LO_W-QUOT_W){1'b0}}, ply_reg}
                  + {{(64-MAG_HI_W-QUOT_W-MAG_LO_W){1'b0}}, phy_reg, {MAG_LO_W{1'b0}}};
    assign act    = cont_reg[ST_MUL] & ~coin_reg[ST_MUL];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            plx_reg <= mag_reg[ST_DIVL][MAG_LO_W-1:0] * dqx_reg[ST_DIVL];
            phx_reg <= mag_reg[ST_DIVL][MAG_W-1:MAG_LO_W] * dqx_reg[ST_DIVL];
            ply_reg <= mag_reg[ST_DIVL][MAG_LO_W-1:0] * dqy_reg[ST_DIVL];
            phy_reg <= mag_reg[ST_DIVL][MAG_W-1:MAG_LO_W] * dqy_reg[ST_DIVL];
            fx_reg  <= sat_force(prod_x, sgx_reg[ST_MUL], act);
            fy_reg  <= sat_force(prod_y, sgy_reg[ST_MUL], act);
        end
    end

    // A coincident or separated pair never carries a force.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1] || !m_tuser[0]) |-> m_tdata[63:0] == 64'd0)
        else $error("force reported for a pair that is not in proper contact");

    // A held result blocks new requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while the output is stalled");

    // An accepted request enters the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v_reg[1])
        else $error("accepted request lost at pipeline entry");

    // A stalled pipeline keeps its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule
`default_nettype wire

// File: tb/sv/tb_soft_disk_pair_interaction_core.sv
// Self-checking testbench for the soft-disk pair interaction core: random and directed pairs.
`timescale 1ns / 1ps
`default_nettype none
module tb_soft_disk_pair_interaction_core;
    import sdpi_pkg::*;

    typedef struct packed {
        logic [15:0] b_angle;
        logic [15:0] a_angle;
        logic [23:0] b_y;
        logic [23:0] b_x;
        logic [23:0] a_y;
        logic [23:0] a_x;
    } pair_t;

    typedef struct {
        logic [79:0] data;
        logic [1:0]  flags;
    } force_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;
    logic [1:0]   m_tuser;

    soft_disk_pair_interaction_core DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    longint unsigned box_half;
    longint unsigned radius;
    longint unsigned spring_k;
    longint unsigned order_m;

    pair_t  pending_pairs[$];
    force_t expected_forces[$];
    int     mismatches;
    bit     calm;
    bit     in_taken;
    int     send_gap;
    int     recv_gap;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint min_image(longint d);
        longint h;
        h = longint'(box_half);
        if (d > h) d = d - 2 * h;
        if (d < -h) d = d + 2 * h;
        return d;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic logic [15:0] sine_q15(longint unsigned phase);
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned xr;
        longint x;
        longint x2;
        longint p;
        longint r;
        phase = phase & 64'hFFFF;
        quad = phase >> 14;
        rem = phase & 64'h3FFF;
        xr = quad[0] ? 64'h4000 - rem : rem;
        x = longint'(xr << 16);
        x2 = (x * x) / 64'sd1073741824;
        p = 64'sd172272;
        p = -64'sd5026995 + (p * x2) / 64'sd1073741824;
        p = 64'sd85569306 + (p * x2) / 64'sd1073741824;
        p = -64'sd693598669 + (p * x2) / 64'sd1073741824;
        p = 64'sd1686629713 + (p * x2) / 64'sd1073741824;
        p = (p * x) / 64'sd1073741824;
        if (p < 0) p = 0;
        r = (p + 64'sd16384) / 64'sd32768;
        if (r > 32767) r = 32767;
        if (quad[1]) r = -r;
        return r[15:0];
    endfunction

    function automatic force_t pair_force(pair_t pr);
        force_t res;
        longint dx;
        longint dy;
        longint unsigned d2;
        longint unsigned twor;
        longint unsigned sep_len;
        longint mag;
        longint ux;
        longint uy;
        longint fx;
        longint fy;
        bit contact;
        bit coinc;
        longint unsigned phase;
        dx = min_image(longint'($signed(pr.b_x)) - longint'($signed(pr.a_x)));
        dy = min_image(longint'($signed(pr.b_y)) - longint'($signed(pr.a_y)));
        d2 = longint'(dx * dx) + longint'(dy * dy);
        twor = 2 * radius;
        contact = d2 < twor * twor;
        coinc = d2 == 0;
        fx = 0;
        fy = 0;
        if (contact && !coinc)
        begin
            sep_len = int_sqrt(d2);
            mag = longint'((spring_k * (twor - sep_len)) >> POS_FRAC_BITS);
            ux = (dx * (64'sd1 << UNIT_BITS)) / longint'(sep_len);
            uy = (dy * (64'sd1 << UNIT_BITS)) / longint'(sep_len);
            fx = (mag * ux) / (64'sd1 << UNIT_BITS);
            fy = (mag * uy) / (64'sd1 << UNIT_BITS);
        end
        phase = ((longint'(pr.a_angle) - longint'(pr.b_angle)) & 64'hFFFF) * order_m;
        res.data = {sine_q15(phase), clamp32(fy), clamp32(fx)};
        res.flags = {coinc, contact};
        return res;
    endfunction

    task automatic write_reg(logic [1:0] idx, longint unsigned val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[31:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_HALF_BOX:       box_half = val & 64'h7FFFFF;
            REG_CONTACT_RADIUS: radius = val & 64'h7FFFFF;
            REG_STIFFNESS:      spring_k = val & 64'hFFFFFFFF;
            REG_ALIGN_ORDER:    order_m = val & 64'hF;
            default:            ;
        endcase
    endtask

    task automatic settle();
        wait (pending_pairs.size() == 0 && expected_forces.size() == 0);
        repeat (60) @(negedge clk);
    endtask

    function automatic logic [23:0] rand_pos();
        return 24'($urandom());
    endfunction

    function automatic logic [23:0] near(logic [23:0] p, int unsigned span);
        return p + 24'($signed($urandom_range(2 * span, 0)) - $signed(span));
    endfunction

    task automatic add_random(int n, int unsigned span);
        pair_t pr;
        repeat (n)
        begin
            pr.a_x = rand_pos();
            pr.a_y = rand_pos();
            pr.a_angle = 16'($urandom());
            pr.b_angle = 16'($urandom());
            if ($urandom_range(9, 0) < 7)
            begin
                pr.b_x = near(pr.a_x, span);
                pr.b_y = near(pr.a_y, span);
            end
            else
            begin
                pr.b_x = rand_pos();
                pr.b_y = rand_pos();
            end
            pending_pairs.insert(pending_pairs.size(), pr);
        end
    endtask

    task automatic add_pair(logic [23:0] ax, logic [23:0] ay, logic [23:0] bx,
                            logic [23:0] by, logic [15:0] aa, logic [15:0] ba);
        pair_t pr;
        pr.a_x = ax;
        pr.a_y = ay;
        pr.b_x = bx;
        pr.b_y = by;
        pr.a_angle = aa;
        pr.b_angle = ba;
        pending_pairs.insert(pending_pairs.size(), pr);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_pairs.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_pairs.pop_front();
                    if (!calm && $urandom_range(5, 0) == 0)
                        send_gap <= $urandom_range(8, 1);
                end
                else
                    s_tvalid <= 1'b0;
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(5, 0) == 0)
                    recv_gap <= $urandom_range(8, 1);
            end
        end
    end

    always @(posedge clk)
    begin
        force_t want;
        in_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
            expected_forces.insert(expected_forces.size(), pair_force(pair_t'(s_tdata)));
        if (m_tvalid && m_tready)
        begin
            if (expected_forces.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result data=%h flags=%b", m_tdata, m_tuser);
            end
            else
            begin
                want = expected_forces.pop_front();
                if (want.data[31:0] !== m_tdata[31:0] || want.data[63:32] !== m_tdata[63:32]
                    || want.data[79:64] !== m_tdata[79:64] || want.flags !== m_tuser)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b, got %h/%b",
                                 want.data, want.flags, m_tdata, m_tuser);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("tb_soft_disk_pair_interaction_core NOT OK");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_HALF_BOX;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        mismatches = 0;
        calm = 1'b0;
        in_taken = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        box_half = HALF_BOX_RESET;
        radius = CONTACT_RADIUS_RESET;
        spring_k = STIFFNESS_RESET;
        order_m = ALIGN_ORDER_RESET;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        add_pair(24'd0, 24'd0, 24'd100, 24'd0, 16'd0, 16'd0);
        add_pair(24'd5, 24'd5, 24'd5, 24'd5, 16'hFFFF, 16'd0);
        settle();

        write_reg(REG_STIFFNESS, 32'h0010_0000);
        write_reg(REG_CONTACT_RADIUS, 23'd65536);
        add_pair(24'd0, 24'd0, 24'd0, 24'd0, 16'h4000, 16'd0);
        add_pair(24'd0, 24'd0, 24'd1, 24'd0, 16'h8000, 16'd0);
        add_pair(24'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 16'hC000, 16'd0);
        add_pair(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 16'd0, 16'hFFFF);
        add_pair(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 16'h2000, 16'h6000);
        add_pair(24'd0, 24'd0, 24'd131071, 24'd0, 16'h1234, 16'h4321);
        add_pair(24'd0, 24'd0, 24'd40000, 24'hFF0000, 16'hFFFF, 16'hFFFF);
        add_pair(24'h0A0000, 24'd0, 24'hF60000, 24'd100, 16'h0001, 16'd0);
        settle();

        write_reg(REG_STIFFNESS, 32'hFFFF_FFFF);
        write_reg(REG_CONTACT_RADIUS, 23'd4194304);
        write_reg(REG_HALF_BOX, 23'd8388607);
        write_reg(REG_ALIGN_ORDER, 4'd8);
        add_pair(24'd0, 24'd0, 24'd1, 24'd1, 16'h1000, 16'd0);
        add_pair(24'h800000, 24'd0, 24'h7FFFFF, 24'd0, 16'h0800, 16'd0);
        add_random(300, 24'h3FFFFF);
        settle();

        write_reg(REG_HALF_BOX, 23'd1);
        write_reg(REG_CONTACT_RADIUS, 23'd1);
        write_reg(REG_ALIGN_ORDER, 4'd0);
        add_random(150, 4);
        settle();

        write_reg(REG_HALF_BOX, 23'd0);
        write_reg(REG_CONTACT_RADIUS, 23'd0);
        write_reg(REG_ALIGN_ORDER, 4'd15);
        add_random(150, 1000);
        settle();

        write_reg(REG_HALF_BOX, 23'd655360);
        write_reg(REG_CONTACT_RADIUS, 23'd6554);
        write_reg(REG_STIFFNESS, 32'h0064_0000);
        write_reg(REG_ALIGN_ORDER, 4'd3);
        add_random(400, 20000);
        settle();

        write_reg(REG_HALF_BOX, $urandom_range(8388607, 1));
        write_reg(REG_CONTACT_RADIUS, $urandom_range(100000, 1));
        write_reg(REG_STIFFNESS, $urandom());
        write_reg(REG_ALIGN_ORDER, $urandom_range(9, 1));
        add_random(400, 200000);
        settle();

        calm = 1'b1;
        add_random(300, 30000);
        settle();

        if (mismatches == 0 && expected_forces.size() == 0)
            $display("tb_soft_disk_pair_interaction_core OK");
        else
            $display("tb_soft_disk_pair_interaction_core NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
